@@ rtl/acolint_pkg.sv @@
package acolint_pkg;

  // Widths of the word fields on the ports.
  localparam int COLOUR_BITS = 32;
  localparam int FIELD_BITS  = 24;
  localparam int STATUS_BITS = 2;

  // Colour layout: four byte channels, blue in the low byte, alpha in the high byte.
  localparam int CHAN_BITS = 8;
  localparam int NUM_CHANS = 4;
  localparam int ALPHA_LSB = 24;

  // One restoring division step per quotient bit.
  localparam int DIV_STEPS = CHAN_BITS;

  // Prepare stage, product stage, then one stage per division step.
  localparam int PIPE_LATENCY = 2 + DIV_STEPS;

  typedef logic [STATUS_BITS-1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_ZERO_SPAN = 2'd1;
  localparam status_t STATUS_CLAMPED   = 2'd2;

  localparam logic KIND_INTERP = 1'b0;
  localparam logic KIND_BLEND  = 1'b1;

  localparam logic [CHAN_BITS-1:0] BLEND_SPAN = 8'hFF;

endpackage

@@ rtl/argb_colour_interpolator_core.sv @@
// A word accepted at a rising edge passes the prepare, multiply and eight division-step
// registers in turn, then shows its result on the out_ ports, marked by out_valid.
// Throughput: one word per clock cycle, sustained; busy is low whenever reset is released.
// The receiver cannot stall, so every stage advances on every cycle.
// Reset is synchronous and active low: it clears the valid bit of every stage and holds
// busy high, so no word is taken while rst_n is low. Payload registers are not reset.
module argb_colour_interpolator_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_kind,
  input  logic [acolint_pkg::COLOUR_BITS-1:0]   in_colour_a,
  input  logic [acolint_pkg::COLOUR_BITS-1:0]   in_colour_b,
  input  logic [acolint_pkg::FIELD_BITS-1:0]    in_position,
  input  logic [acolint_pkg::FIELD_BITS-1:0]    in_span,
  output logic                                  out_valid,
  output logic [acolint_pkg::COLOUR_BITS-1:0]   out_mixed_colour,
  output acolint_pkg::status_t                  out_status
);

  // Internal arithmetic only uses the low POSITION_BITS bits of position and span.
  // For a non-zero span the numerator a*(span-pos) + b*pos never exceeds 255*span, so it fits in
  // POSITION_BITS + 8 bits and the quotient always fits in one byte.
  localparam int PB = POSITION_BITS;
  localparam int NW = POSITION_BITS + acolint_pkg::CHAN_BITS;
  localparam int CB = acolint_pkg::CHAN_BITS;
  localparam int NC = acolint_pkg::NUM_CHANS;
  localparam int DS = acolint_pkg::DIV_STEPS;

  // The block is always ready outside reset: the pipeline never backs up.
  assign busy = ~rst_n;

  // ---------------------------------------------------------------------------
  // Stage 1: choose the mode, mask the fields, detect a zero span and clamp.
  // In blend mode the alpha byte of colour_b is the position and the span is 255.
  // ---------------------------------------------------------------------------
  logic [PB-1:0]                         pos_sel;
  logic [PB-1:0]                         span_sel;
  logic [PB-1:0]                         s1_pos_nxt;
  logic [PB-1:0]                         s1_diff_nxt;
  acolint_pkg::status_t                  s1_status_nxt;
  logic                                  s1_valid_nxt;

  logic                                  s1_valid_r;
  logic [acolint_pkg::COLOUR_BITS-1:0]   s1_ca_r;
  logic [acolint_pkg::COLOUR_BITS-1:0]   s1_cb_r;
  logic [PB-1:0]                         s1_pos_r;
  logic [PB-1:0]                         s1_diff_r;
  logic [PB-1:0]                         s1_span_r;
  acolint_pkg::status_t                  s1_status_r;

  assign s1_valid_nxt = start & ~busy;

  always_comb begin
    pos_sel  = in_position[PB-1:0];
    span_sel = in_span[PB-1:0];
    if (in_kind == acolint_pkg::KIND_BLEND) begin
      pos_sel  = PB'(in_colour_b[acolint_pkg::ALPHA_LSB +: CB]);
      span_sel = PB'(acolint_pkg::BLEND_SPAN);
    end
    s1_pos_nxt    = pos_sel;
    s1_status_nxt = acolint_pkg::STATUS_OK;
    if (span_sel == '0) begin
      s1_status_nxt = acolint_pkg::STATUS_ZERO_SPAN;
    end else if (pos_sel > span_sel) begin
      // A position past the end is taken as the end, which gives colour_b.
      s1_pos_nxt    = span_sel;
      s1_status_nxt = acolint_pkg::STATUS_CLAMPED;
    end
    // With a zero span this difference wraps; the colour is forced to zero later.
    s1_diff_nxt = span_sel - s1_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ca_r     <= in_colour_a;
    s1_cb_r     <= in_colour_b;
    s1_pos_r    <= s1_pos_nxt;
    s1_diff_r   <= s1_diff_nxt;
    s1_span_r   <= span_sel;
    s1_status_r <= s1_status_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: form the numerator of every channel, a*(span-pos) + b*pos.
  // Each channel needs two small 8 by POSITION_BITS products and one add.
  // ---------------------------------------------------------------------------
  logic [NW-1:0]           num_nxt [NC];

  // Division pipeline registers. Index 0 holds the product stage; index k+1 holds
  // the word after division step k. Remainder and divisor are not needed after the
  // last step, so those arrays stop one short.
  logic [NW-1:0]           rem_r   [DS][NC];
  logic [PB-1:0]           dspan_r [DS];
  logic [CB-1:0]           quo_r   [DS+1][NC];
  acolint_pkg::status_t    dstat_r [DS+1];
  logic                    dvalid_r[DS+1];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      num_nxt[c] = NW'(s1_ca_r[c*CB +: CB]) * NW'(s1_diff_r)
                 + NW'(s1_cb_r[c*CB +: CB]) * NW'(s1_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r[0] <= 1'b0;
    end else begin
      dvalid_r[0] <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      rem_r[0][c] <= num_nxt[c];
      quo_r[0][c] <= '0;
    end
    dspan_r[0] <= s1_span_r;
    dstat_r[0] <= s1_status_r;
  end

  // ---------------------------------------------------------------------------
  // Stages 3 to 10: restoring division, most significant quotient bit first.
  // Step k tries to take span shifted left by (7 - k) from the remainder of each
  // channel; when it fits, that quotient bit is set. Since the quotient is below
  // 256, eight steps give the exact floor.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DS; k++) begin : g_div
    localparam int SH = DS - 1 - k;

    logic [NW-1:0] trial;
    logic [NW-1:0] rem_nxt [NC];
    logic [CB-1:0] quo_nxt [NC];

    always_comb begin
      trial = NW'(dspan_r[k]) << SH;
      for (int c = 0; c < NC; c++) begin
        rem_nxt[c] = rem_r[k][c];
        quo_nxt[c] = quo_r[k][c];
        if (rem_r[k][c] >= trial) begin
          rem_nxt[c]     = rem_r[k][c] - trial;
          quo_nxt[c][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvalid_r[k+1] <= 1'b0;
      end else begin
        dvalid_r[k+1] <= dvalid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int c = 0; c < NC; c++) begin
        quo_r[k+1][c] <= quo_nxt[c];
      end
      dstat_r[k+1] <= dstat_r[k];
    end

    if (k < DS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        for (int c = 0; c < NC; c++) begin
          rem_r[k+1][c] <= rem_nxt[c];
        end
        dspan_r[k+1] <= dspan_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result: pack the four channel bytes; a zero span gives a black, transparent word.
  // ---------------------------------------------------------------------------
  assign out_valid  = dvalid_r[DS];
  assign out_status = dstat_r[DS];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (dstat_r[DS] == acolint_pkg::STATUS_ZERO_SPAN) begin
        out_mixed_colour[c*CB +: CB] = '0;
      end else begin
        out_mixed_colour[c*CB +: CB] = quo_r[DS][c];
      end
    end
  end

endmodule

@@ rtl/acolint_check.sv @@
module acolint_check #(
  parameter int POSITION_BITS = 24
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 in_kind,
  input logic [acolint_pkg::FIELD_BITS-1:0]   in_span,
  input logic                                 out_valid,
  input logic [acolint_pkg::COLOUR_BITS-1:0]  out_mixed_colour,
  input acolint_pkg::status_t                 out_status
);

  localparam int LAT = acolint_pkg::PIPE_LATENCY;

  // Every accepted word gives exactly one result, a fixed number of cycles later.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, LAT))
    else $error("result strobe does not match a word accepted %0d cycles earlier", LAT);

  // A zero span always yields an all-zero colour.
  a_zero_colour: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == acolint_pkg::STATUS_ZERO_SPAN) |-> (out_mixed_colour == '0))
    else $error("zero span result carries a non-zero colour");

  // Blend mode can neither see a zero span nor clamp.
  a_blend_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == acolint_pkg::KIND_BLEND)
      |-> ##LAT (out_valid && out_status == acolint_pkg::STATUS_OK))
    else $error("blend word did not finish with status ok");

  // An interpolation with a zero span, after masking, is flagged as such.
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == acolint_pkg::KIND_INTERP
      && in_span[POSITION_BITS-1:0] == '0)
      |-> ##LAT (out_valid && out_status == acolint_pkg::STATUS_ZERO_SPAN))
    else $error("zero span word was not flagged");

endmodule

bind argb_colour_interpolator_core acolint_check #(
  .POSITION_BITS(POSITION_BITS)
) u_acolint_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_kind          (in_kind),
  .in_span          (in_span),
  .out_valid        (out_valid),
  .out_mixed_colour (out_mixed_colour),
  .out_status       (out_status)
);

@@ tb/sv/argb_colour_interpolator_core_tb.sv @@
module argb_colour_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its full position width, so no bit of the
  // position or span ports is ignored. The mask is kept so that the
  // predictor follows the same rule as the block for narrower builds.
  localparam int POS_BITS   = 24;
  localparam int CLK_PERIOD = 10;
  localparam int RAND_WORDS = 550;
  localparam int FIELD_W    = acolint_pkg::FIELD_BITS;
  localparam logic [acolint_pkg::FIELD_BITS-1:0] FIELD_MASK = FIELD_W'((1 << POS_BITS) - 1);
  localparam logic [acolint_pkg::FIELD_BITS-1:0] FIELD_MAX  = '1;
  localparam logic [acolint_pkg::COLOUR_BITS-1:0] WHITE     = '1;

  // One word offered to the block on the input channel.
  typedef struct packed {
    logic                                kind;
    logic [acolint_pkg::COLOUR_BITS-1:0] colour_a;
    logic [acolint_pkg::COLOUR_BITS-1:0] colour_b;
    logic [acolint_pkg::FIELD_BITS-1:0]  position;
    logic [acolint_pkg::FIELD_BITS-1:0]  span;
  } pixel_word_t;

  // One word expected back on the result channel.
  typedef struct packed {
    logic [acolint_pkg::COLOUR_BITS-1:0] colour;
    acolint_pkg::status_t                status;
  } mixed_pixel_t;

  logic                                clk   = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                in_kind     = acolint_pkg::KIND_INTERP;
  logic [acolint_pkg::COLOUR_BITS-1:0] in_colour_a = '0;
  logic [acolint_pkg::COLOUR_BITS-1:0] in_colour_b = '0;
  logic [acolint_pkg::FIELD_BITS-1:0]  in_position = '0;
  logic [acolint_pkg::FIELD_BITS-1:0]  in_span     = '0;
  logic                                out_valid;
  logic [acolint_pkg::COLOUR_BITS-1:0] out_mixed_colour;
  acolint_pkg::status_t                out_status;

  // Words still to be offered, and mixed pixels still to come back, oldest first.
  pixel_word_t  pending_words[$];
  mixed_pixel_t expected_pixels[$];

  int total_words    = 0;
  int words_taken    = 0;
  int mismatch_count = 0;

  // The sender works in bursts: burst_left words are offered back to back,
  // then start is held low while gap_left counts down before the next burst.
  int burst_left = 8;
  int gap_left   = 0;

  argb_colour_interpolator_core #(
    .POSITION_BITS(POS_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_colour_a      (in_colour_a),
    .in_colour_b      (in_colour_b),
    .in_position      (in_position),
    .in_span          (in_span),
    .out_valid        (out_valid),
    .out_mixed_colour (out_mixed_colour),
    .out_status       (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicts the mixed pixel for one word. Each byte channel becomes
  // floor((a * (span - pos) + b * pos) / span), worked out at a width where
  // nothing can wrap. In blend mode the alpha byte of colour b is the weight
  // and the span is fixed at 255, so neither special status can arise there.
  function automatic mixed_pixel_t mix_argb(logic kind,
                                            logic [acolint_pkg::COLOUR_BITS-1:0] ca,
                                            logic [acolint_pkg::COLOUR_BITS-1:0] cb,
                                            logic [acolint_pkg::FIELD_BITS-1:0] pos_in,
                                            logic [acolint_pkg::FIELD_BITS-1:0] span_in);
    logic [47:0]  pos;
    logic [47:0]  span;
    logic [47:0]  weighted_sum;
    logic [47:0]  quotient;
    mixed_pixel_t pixel;
    pos          = 48'(pos_in & FIELD_MASK);
    span         = 48'(span_in & FIELD_MASK);
    pixel.colour = '0;
    pixel.status = acolint_pkg::STATUS_OK;
    if (kind == acolint_pkg::KIND_BLEND) begin
      pos  = 48'(cb[acolint_pkg::ALPHA_LSB +: acolint_pkg::CHAN_BITS]);
      span = 48'(acolint_pkg::BLEND_SPAN);
    end
    if (span == 0) begin
      // A zero span cannot divide: the colour is forced to zero and flagged.
      pixel.status = acolint_pkg::STATUS_ZERO_SPAN;
    end else begin
      // A position beyond the end of the span is pinned to the end, which
      // yields colour b exactly.
      if (pos > span) begin
        pos          = span;
        pixel.status = acolint_pkg::STATUS_CLAMPED;
      end
      for (int ch = 0; ch < acolint_pkg::NUM_CHANS; ch++) begin
        weighted_sum =
          48'(ca[ch*acolint_pkg::CHAN_BITS +: acolint_pkg::CHAN_BITS]) * (span - pos)
          + 48'(cb[ch*acolint_pkg::CHAN_BITS +: acolint_pkg::CHAN_BITS]) * pos;
        quotient     = weighted_sum / span;
        pixel.colour[ch*acolint_pkg::CHAN_BITS +: acolint_pkg::CHAN_BITS] =
          quotient[acolint_pkg::CHAN_BITS-1:0];
      end
    end
    return pixel;
  endfunction

  task automatic queue_word(logic kind, logic [acolint_pkg::COLOUR_BITS-1:0] ca,
                            logic [acolint_pkg::COLOUR_BITS-1:0] cb,
                            logic [acolint_pkg::FIELD_BITS-1:0] pos,
                            logic [acolint_pkg::FIELD_BITS-1:0] span);
    pixel_word_t w;
    w.kind     = kind;
    w.colour_a = ca;
    w.colour_b = cb;
    w.position = pos;
    w.span     = span;
    pending_words.push_back(w);
  endtask

  // Picks a colour: mostly fully random, now and then black or white so that
  // the channel extremes keep turning up in the random part as well.
  function automatic logic [acolint_pkg::COLOUR_BITS-1:0] pick_colour();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return WHITE;
    end
    return $urandom;
  endfunction

  // Driver. At every rising edge it first notes whether the word on the ports
  // has just been taken, predicting its result if so, and then decides what
  // to offer next. A word that has not been taken is held as it is. Each
  // port gets at most one assignment per edge.
  always @(posedge clk) begin : drive_words
    pixel_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_pixels.push_back(mix_argb(in_kind, in_colour_a, in_colour_b,
                                           in_position, in_span));
        words_taken++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_kind     <= w.kind;
          in_colour_a <= w.colour_a;
          in_colour_b <= w.colour_b;
          in_position <= w.position;
          in_span     <= w.span;
          start       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // A quarter of the bursts are long and unbroken, so the pipeline
            // also sees stretches of full-rate traffic.
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(40, 80);
            end else begin
              burst_left = $urandom_range(1, 12);
            end
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every strobed result is taken at the edge that ends its cycle
  // and compared field by field with the oldest prediction.
  always @(posedge clk) begin : check_results
    mixed_pixel_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual colour %h status %0d",
                 $time, out_mixed_colour, out_status);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_mixed_colour !== want.colour) begin
          $display("%0t: mixed colour mismatch, expected %h, actual %h",
                   $time, want.colour, out_mixed_colour);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : run_test
    logic [acolint_pkg::FIELD_BITS-1:0] span;
    logic [acolint_pkg::FIELD_BITS-1:0] pos;
    int                                 sel;

    // Directed words. Interpolation at both ends of the span first, then
    // the zero span and clamped positions, the widest spans, then other fractions.
    queue_word(acolint_pkg::KIND_INTERP, '0, WHITE, '0, 24'd1);
    queue_word(acolint_pkg::KIND_INTERP, '0, WHITE, 24'd1, 24'd1);
    queue_word(acolint_pkg::KIND_INTERP, 32'h12345678, 32'h9ABCDEF0, '0, '0);
    queue_word(acolint_pkg::KIND_INTERP, WHITE, WHITE, FIELD_MAX, '0);
    queue_word(acolint_pkg::KIND_INTERP, 32'h11223344, 32'h55667788, 24'd5, 24'd4);
    queue_word(acolint_pkg::KIND_INTERP, 32'hCAFE0123, 32'h0BADF00D, FIELD_MAX, 24'd1);
    queue_word(acolint_pkg::KIND_INTERP, WHITE, '0, FIELD_MAX - 1, FIELD_MAX);
    queue_word(acolint_pkg::KIND_INTERP, '0, WHITE, FIELD_MAX, FIELD_MAX);
    queue_word(acolint_pkg::KIND_INTERP, WHITE, WHITE, 24'd1, FIELD_MAX);
    queue_word(acolint_pkg::KIND_INTERP, 32'h12345678, 32'h89ABCDEF, 24'd3, 24'd7);
    queue_word(acolint_pkg::KIND_INTERP, '0, WHITE, 24'd128, 24'd255);
    queue_word(acolint_pkg::KIND_INTERP, 32'hA5A5A5A5, 32'h5A5A5A5A, 24'd2, 24'd3);
    queue_word(acolint_pkg::KIND_INTERP, 32'h0F0F0F0F, 32'hF0F0F0F0, 24'h800000,
               24'h800000);
    // Blend mode: transparent, opaque and half-covered source colours. The
    // position and span ports carry nonsense here, which must be ignored,
    // including a zero span that would be flagged in interpolate mode.
    queue_word(acolint_pkg::KIND_BLEND, 32'hFF000000, 32'h00FFFFFF, 24'd7, 24'd3);
    queue_word(acolint_pkg::KIND_BLEND, 32'h80808080, 32'hFF123456, '0, '0);
    queue_word(acolint_pkg::KIND_BLEND, 32'h00FF00FF, 32'h80FF8000, FIELD_MAX, '0);
    queue_word(acolint_pkg::KIND_BLEND, WHITE, 32'h01000000, FIELD_MAX, FIELD_MAX);
    queue_word(acolint_pkg::KIND_BLEND, '0, WHITE, 24'h123456, 24'h654321);

    // Random words. Spans are drawn from several bands so that tiny, byte
    // sized and full width divisors all appear, and positions mostly lie
    // within the span with a share at its end, beyond it or fully random.
    for (int n = 0; n < RAND_WORDS; n++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        span = '0;
      end else if (sel <= 3) begin
        span = FIELD_W'($urandom_range(1, 16));
      end else if (sel == 4) begin
        span = 24'd255;
      end else if (sel <= 7) begin
        span = FIELD_W'($urandom);
      end else begin
        span = FIELD_W'($urandom_range(1, 1000));
      end
      sel = $urandom_range(0, 9);
      if (sel <= 6) begin
        pos = FIELD_W'($urandom_range(0, span));
      end else if (sel == 7) begin
        pos = span;
      end else if (sel == 8 && span != FIELD_MAX) begin
        pos = FIELD_W'($urandom_range(span + 1, FIELD_MAX));
      end else begin
        pos = FIELD_W'($urandom);
      end
      queue_word(1'($urandom_range(0, 1)), pick_colour(), pick_colour(), pos, span);
    end
    total_words = pending_words.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word has been taken, then until every prediction has
    // been met, then a little longer so that any stray result shows up.
    while (words_taken < total_words) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (acolint_pkg::PIPE_LATENCY + 4) @(posedge clk);

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog. A millisecond is far longer than the slowest correct run, so
  // it only trips when the block has stopped answering.
  initial begin : watchdog
    #1ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/acolint_pkg.sv
rtl/argb_colour_interpolator_core.sv
rtl/acolint_check.sv
tb/sv/argb_colour_interpolator_core_tb.sv
